// ----- rtl/bbr_pkg.sv -----
// Shared constants, codes and item types for the bitstream bit reader.
package bbr_pkg;

  localparam int BUF_W      = 64;
  localparam int CNT_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int SHAMT_W    = $clog2(BUF_W);
  localparam int PUSH_LIMIT = BUF_W - BYTE_W;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam logic ORDER_MSB = 1'b0;
  localparam logic ORDER_LSB = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [BYTE_W-1:0]  byte_in;
    logic [CNT_W-1:0]   count;
  } item_t;

  typedef struct packed {
    logic [BUF_W-1:0]   field_value;
    logic [CNT_W-1:0]   bits_held;
    status_t            status;
  } result_t;

endpackage

// ----- rtl/bbr_in_stage.sv -----
// Input register stage: holds one accepted item until the core takes it.
module bbr_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbr_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output bbr_pkg::item_t item
);
  import bbr_pkg::*;

  logic load;

  assign in_ready = !item_valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= load || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/bbr_core.sv -----
// Bit buffer state and the single-pass push / read / peek / clear logic.
module bbr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_order,
  input  logic             advance,
  input  bbr_pkg::item_t   item,
  output bbr_pkg::result_t result
);
  import bbr_pkg::*;

  logic [BUF_W-1:0]   bit_buffer, bit_buffer_next;
  logic [CNT_W-1:0]   bit_count, bit_count_next;
  logic               bit_order;

  logic [CNT_W-1:0]   n;
  logic               full;
  logic               whole;
  logic [SHAMT_W-1:0] push_pos;
  logic [SHAMT_W-1:0] msb_sh;
  logic [BUF_W-1:0]   lsb_mask;
  logic [BUF_W-1:0]   value;
  logic [BUF_W-1:0]   shifted;
  status_t            status;

  always_comb begin
    n        = item.count;
    full     = bit_count > CNT_W'(PUSH_LIMIT);
    whole    = (n == CNT_W'(BUF_W));
    push_pos = (bit_order == ORDER_LSB) ? bit_count[SHAMT_W-1:0]
                                        : SHAMT_W'(CNT_W'(PUSH_LIMIT) - bit_count);
    msb_sh   = SHAMT_W'(CNT_W'(BUF_W) - n);
    lsb_mask = whole ? {BUF_W{1'b1}} : ~({BUF_W{1'b1}} << n[SHAMT_W-1:0]);

    if (bit_order == ORDER_LSB) begin
      shifted = whole ? '0 : (bit_buffer >> n[SHAMT_W-1:0]);
    end else begin
      shifted = whole ? '0 : (bit_buffer << n[SHAMT_W-1:0]);
    end

    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    value           = '0;
    status          = ST_OK;

    case (item.func)
      FUNC_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          bit_buffer_next = bit_buffer | (BUF_W'(item.byte_in) << push_pos);
          bit_count_next  = bit_count + CNT_W'(BYTE_W);
        end
      end
      FUNC_CLEAR: begin
        bit_buffer_next = '0;
        bit_count_next  = '0;
      end
      FUNC_READ, FUNC_PEEK: begin
        if (n > bit_count) begin
          status = ST_SHORT;
        end else if (n != '0) begin
          value = (bit_order == ORDER_LSB) ? (bit_buffer & lsb_mask)
                                           : (bit_buffer >> msb_sh);
          if (item.func == FUNC_READ) begin
            bit_buffer_next = shifted;
            bit_count_next  = bit_count - n;
          end
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    result.field_value = value;
    result.bits_held   = bit_count_next;
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_count  <= '0;
      bit_order  <= ORDER_MSB;
    end else begin
      if (advance) begin
        bit_buffer <= bit_buffer_next;
        bit_count  <= bit_count_next;
      end
      if (cfg_we) begin
        bit_order <= cfg_order;
      end
    end
  end

endmodule

// ----- rtl/bbr_out_stage.sv -----
// Result register stage: holds one result until the downstream side takes it.
module bbr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bbr_pkg::result_t  result_in,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output bbr_pkg::result_t  result
);
  import bbr_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ----- rtl/bitstream_bit_reader.sv -----
// Bitstream bit reader: pushes bytes into a 64-bit buffer and extracts fields of 0 to 64 bits,
// MSB-first or LSB-first as set by the bit order register. One item a cycle sustained while
// m_axis_tready is high; a result is offered on m_axis once its item has passed the input and
// result registers; the buffer update between them sets the rate. The user must write the bit
// order register through cfg_* only while no item is in flight; the block does not check it.
module bitstream_bit_reader (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bbr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // byte_in[7:0], count[14:8], pad
  input  logic [bbr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // func[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bbr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // field_value[63:0], bits_held[70:64], pad
  output logic [bbr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // status[1:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_data       // bit_order
);
  import bbr_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t core_result;
  result_t out_result;
  logic    item_valid;
  logic    space;
  logic    advance;

  assign in_item.func    = func_t'(s_axis_tuser);
  assign in_item.byte_in = s_axis_tdata[BYTE_W-1:0];
  assign in_item.count   = s_axis_tdata[BYTE_W +: CNT_W];

  assign advance   = item_valid && space;
  assign cfg_ready = 1'b1;

  bbr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bbr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_order (cfg_data[0]),
    .advance   (advance),
    .item      (item),
    .result    (core_result)
  );

  bbr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (core_result),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (out_result)
  );

  assign m_axis_tdata = {1'b0, out_result.bits_held, out_result.field_value};
  assign m_axis_tuser = out_result.status;

endmodule

// ----- rtl/bbr_checker.sv -----
// Port-level checks for the bitstream bit reader, bound to the top level.
module bbr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bbr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [bbr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import bbr_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[BUF_W +: CNT_W] <= CNT_W'(BUF_W))
    else $error("bits held beyond buffer width");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL
                      || m_axis_tuser == ST_SHORT)
    else $error("undefined status");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[BUF_W-1:0] == '0)
    else $error("refused item carries a field value");

endmodule

bind bitstream_bit_reader bbr_checker u_bbr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
